@@ sv/graf_pkg.sv @@
package graf_pkg;

  // Geometry of one descriptor in the public flash window.
  localparam int unsigned DESCRIPTOR_BYTES = 20;
  localparam logic [32:0] DESC_LAST_OFS    = 33'(DESCRIPTOR_BYTES - 1);

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned DATA_W     = 32;

  // Allowed target windows: peripheral space and the system control page.
  localparam logic [31:0] PERIPH_MASK = 32'hFC00_0000;
  localparam logic [31:0] PERIPH_BASE = 32'h4000_0000;
  localparam logic [31:0] SYS_MASK    = 32'hFFFF_F000;
  localparam logic [31:0] SYS_BASE    = 32'hE00F_F000;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_FLASH_LOW   = 2'd0,
    REG_FLASH_HIGH  = 2'd1,
    REG_MAGIC       = 2'd2,
    REG_OWNER_TABLE = 2'd3
  } reg_idx_t;

  // Result status codes, in the order the checks are applied.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FLASH     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_OWNER_PTR = 3'd3,
    ST_OWNER     = 3'd4,
    ST_ADDRESS   = 3'd5,
    ST_WIDTH     = 3'd6,
    ST_OP        = 3'd7
  } status_t;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_READ_AND  = 3'd1,
    OP_WRITE     = 3'd2,
    OP_WRITE_AND = 3'd3,
    OP_WRITE_OR  = 3'd4,
    OP_WRITE_XOR = 3'd5,
    OP_REPLACE   = 3'd6,
    OP_INVALID   = 3'd7
  } op_t;

  // Access widths in bytes.
  localparam logic [3:0] WIDTH_BYTE = 4'd1;
  localparam logic [3:0] WIDTH_HALF = 4'd2;
  localparam logic [3:0] WIDTH_WORD = 4'd4;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [31:0] flash_low;
    logic [31:0] flash_high;
    logic [31:0] expected_magic;
    logic [31:0] owner_table_start;
  } cfg_t;

  // One registered request.
  typedef struct packed {
    logic [31:0] descriptor_addr;
    logic [31:0] descriptor_magic;
    logic [31:0] owner_ptr;
    logic [2:0]  req_type;
    logic [3:0]  width_bytes;
    logic        is_shared;
    logic [31:0] target_addr;
    logic [31:0] bit_mask;
    logic [31:0] write_value;
    logic [31:0] current_data;
    logic [7:0]  active_owner;
  } req_t;

  // One computed result.
  typedef struct packed {
    status_t     status;
    logic        do_write;
    logic [31:0] write_data;
    logic [31:0] read_result;
  } res_t;

  // Byte-lane mask for an access width; any other width keeps all lanes.
  function automatic logic [31:0] width_mask(input logic [3:0] w);
    logic [31:0] m;
    if (w == WIDTH_BYTE) begin
      m = 32'h0000_00FF;
    end else if (w == WIDTH_HALF) begin
      m = 32'h0000_FFFF;
    end else begin
      m = 32'hFFFF_FFFF;
    end
    return m;
  endfunction

endpackage

@@ sv/guarded_register_access_filter_unit.sv @@
// Channel   Ports                                              Beat taken when
// --------  -------------------------------------------------  ---------------------------
// request   start, busy, descriptor_addr .. active_owner       start && !busy
// result    done, status, do_write, write_data, read_result    done (one cycle, no stall)
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  psel && penable && pwrite
//
// A request beat is registered at the accepting edge, checked and evaluated in the next
// cycle, and its result beat is captured in the result register and then shows on the
// result ports for one cycle. busy stays low, so a new request beat may come in every
// cycle; the rate is one per cycle, set by the single check-and-compute stage between the
// two registers. rst is synchronous and active high; it clears the configuration registers
// and the valid flags of both stages. The receiver cannot stall, so nothing ever backs up.
module guarded_register_access_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [graf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [graf_pkg::DATA_W-1:0]      pwdata,
  output logic [graf_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // Request
  input  logic                             start,
  output logic                             busy,
  input  logic [31:0]                      descriptor_addr,
  input  logic [31:0]                      descriptor_magic,
  input  logic [31:0]                      owner_ptr,
  input  logic [2:0]                       req_type,
  input  logic [3:0]                       width_bytes,
  input  logic                             is_shared,
  input  logic [31:0]                      target_addr,
  input  logic [31:0]                      bit_mask,
  input  logic [31:0]                      write_value,
  input  logic [31:0]                      current_data,
  input  logic [7:0]                       active_owner,
  // Result
  output logic                             done,
  output logic [2:0]                       status,
  output logic                             do_write,
  output logic [31:0]                      write_data,
  output logic [31:0]                      read_result
);

  graf_pkg::cfg_t    cfg;
  graf_pkg::req_t    req;
  logic              req_valid;
  graf_pkg::status_t chk_status;
  graf_pkg::res_t    res_next;
  graf_pkg::res_t    res;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  graf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.descriptor_addr  <= descriptor_addr;
      req.descriptor_magic <= descriptor_magic;
      req.owner_ptr        <= owner_ptr;
      req.req_type         <= req_type;
      req.width_bytes      <= width_bytes;
      req.is_shared        <= is_shared;
      req.target_addr      <= target_addr;
      req.bit_mask         <= bit_mask;
      req.write_value      <= write_value;
      req.current_data     <= current_data;
      req.active_owner     <= active_owner;
    end
  end

  graf_check u_check (
    .cfg    (cfg),
    .req    (req),
    .status (chk_status)
  );

  graf_op u_op (
    .req    (req),
    .status (chk_status),
    .res    (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      res <= res_next;
    end
  end

  assign status      = res.status;
  assign do_write    = res.do_write;
  assign write_data  = res.write_data;
  assign read_result = res.read_result;

`ifndef ASSERT_OFF
  // Every registered request yields exactly one result beat in the next cycle.
  a_valid_to_done: assert property (@(posedge clk) disable iff (rst)
    req_valid |=> done)
    else $error("registered request produced no result beat");

  // A result beat only comes from a request held in the input register.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_valid))
    else $error("result beat without a registered request");

  // A rejected request never writes and returns no data.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status != graf_pkg::ST_OK)) |->
      (!do_write && (write_data == '0) && (read_result == '0)))
    else $error("rejected request carries write or read data");

  // A write beat never also returns read data.
  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    (done && do_write) |-> (read_result == '0))
    else $error("write beat with nonzero read result");
`endif

endmodule

@@ sv/graf_cfg.sv @@
module graf_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [graf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [graf_pkg::DATA_W-1:0]       pwdata,
  output logic [graf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output graf_pkg::cfg_t                    cfg
);

  graf_pkg::reg_idx_t idx;
  logic               wr_en;

  // Word index and write strobe of the access phase.
  assign idx    = graf_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        graf_pkg::REG_FLASH_LOW:   cfg.flash_low         <= pwdata;
        graf_pkg::REG_FLASH_HIGH:  cfg.flash_high        <= pwdata;
        graf_pkg::REG_MAGIC:       cfg.expected_magic    <= pwdata;
        graf_pkg::REG_OWNER_TABLE: cfg.owner_table_start <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      graf_pkg::REG_FLASH_LOW:   prdata = cfg.flash_low;
      graf_pkg::REG_FLASH_HIGH:  prdata = cfg.flash_high;
      graf_pkg::REG_MAGIC:       prdata = cfg.expected_magic;
      graf_pkg::REG_OWNER_TABLE: prdata = cfg.owner_table_start;
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ sv/graf_check.sv @@
module graf_check (
  input  graf_pkg::cfg_t    cfg,
  input  graf_pkg::req_t    req,
  output graf_pkg::status_t status
);

  logic [32:0] last_addr;
  logic        flash_ok;
  logic [32:0] owner_diff;
  logic        ptr_low;
  logic [7:0]  owner_id;
  logic        owner_ok;
  logic        target_ok;
  logic        width_ok;

  // Descriptor must lie wholly inside the flash window without wrapping.
  assign last_addr = {1'b0, req.descriptor_addr} + graf_pkg::DESC_LAST_OFS;
  assign flash_ok  = !last_addr[32]
                  && (req.descriptor_addr >= cfg.flash_low)
                  && (req.descriptor_addr <= cfg.flash_high)
                  && (last_addr[31:0] >= cfg.flash_low)
                  && (last_addr[31:0] <= cfg.flash_high);

  // Owner pointer offset; the borrow flags a pointer below the table.
  assign owner_diff = {1'b0, req.owner_ptr} - {1'b0, cfg.owner_table_start};
  assign ptr_low    = owner_diff[32];
  assign owner_id   = owner_diff[9:2];
  assign owner_ok   = req.is_shared || (owner_id == req.active_owner);

  // Target must fall in one of the two allowed windows.
  assign target_ok = ((req.target_addr & graf_pkg::PERIPH_MASK) == graf_pkg::PERIPH_BASE)
                  || ((req.target_addr & graf_pkg::SYS_MASK) == graf_pkg::SYS_BASE);

  assign width_ok = (req.width_bytes == graf_pkg::WIDTH_BYTE)
                 || (req.width_bytes == graf_pkg::WIDTH_HALF)
                 || (req.width_bytes == graf_pkg::WIDTH_WORD);

  // First failing check sets the status.
  always_comb begin
    priority if (!flash_ok) begin
      status = graf_pkg::ST_FLASH;
    end else if (req.descriptor_magic != cfg.expected_magic) begin
      status = graf_pkg::ST_MAGIC;
    end else if (ptr_low) begin
      status = graf_pkg::ST_OWNER_PTR;
    end else if (!owner_ok) begin
      status = graf_pkg::ST_OWNER;
    end else if (!target_ok) begin
      status = graf_pkg::ST_ADDRESS;
    end else if (!width_ok) begin
      status = graf_pkg::ST_WIDTH;
    end else if (graf_pkg::op_t'(req.req_type) == graf_pkg::OP_INVALID) begin
      status = graf_pkg::ST_OP;
    end else begin
      status = graf_pkg::ST_OK;
    end
  end

endmodule

@@ sv/graf_op.sv @@
module graf_op (
  input  graf_pkg::req_t    req,
  input  graf_pkg::status_t status,
  output graf_pkg::res_t    res
);

  logic [31:0] wm;
  logic [31:0] cur;
  logic [31:0] rd;
  logic [31:0] wr;
  logic        dw;

  // Present contents narrowed to the access width.
  assign wm  = graf_pkg::width_mask(req.width_bytes);
  assign cur = req.current_data & wm;

  // Operation datapath.
  always_comb begin
    rd = '0;
    wr = '0;
    dw = 1'b0;
    unique case (graf_pkg::op_t'(req.req_type))
      graf_pkg::OP_READ:      rd = cur;
      graf_pkg::OP_READ_AND:  rd = cur & req.bit_mask;
      graf_pkg::OP_WRITE: begin
        wr = req.write_value;
        dw = 1'b1;
      end
      graf_pkg::OP_WRITE_AND: begin
        wr = cur & (req.write_value | ~req.bit_mask);
        dw = 1'b1;
      end
      graf_pkg::OP_WRITE_OR: begin
        wr = cur | (req.write_value & req.bit_mask);
        dw = 1'b1;
      end
      graf_pkg::OP_WRITE_XOR: begin
        wr = cur ^ (req.write_value & req.bit_mask);
        dw = 1'b1;
      end
      graf_pkg::OP_REPLACE: begin
        wr = (cur & ~req.bit_mask) | (req.write_value & req.bit_mask);
        dw = 1'b1;
      end
      default: ;
    endcase
  end

  // A rejected request returns all zeros besides its status.
  always_comb begin
    res.status = status;
    if (status == graf_pkg::ST_OK) begin
      res.do_write    = dw;
      res.write_data  = wr & wm;
      res.read_result = rd;
    end else begin
      res.do_write    = 1'b0;
      res.write_data  = '0;
      res.read_result = '0;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned RESET_ROWS   = 2;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned IDLE_LIMIT   = 5000;

  // Register setting used by the directed rows after the reset rows.
  localparam logic [31:0] DIR_FLASH_LOW  = 32'h0800_0000;
  localparam logic [31:0] DIR_FLASH_HIGH = 32'h0803_FFFF;
  localparam logic [31:0] DIR_MAGIC      = 32'h5AFE_C0DE;
  localparam logic [31:0] DIR_TABLE      = 32'h2000_0000;

  // One row of the directed table; known marks an expectation typed in by hand.
  typedef struct {
    graf_pkg::req_t beat;
    logic           known;
    graf_pkg::res_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [graf_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [graf_pkg::DATA_W-1:0]     pwdata  = '0;
  logic [graf_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  logic           start    = 1'b0;
  logic           busy;
  graf_pkg::req_t req_beat = '0;
  logic           done;
  logic [2:0]     status;
  logic           do_write;
  logic [31:0]    write_data;
  logic [31:0]    read_result;

  // Predictor state: a private copy of the registers and the outcomes in flight.
  graf_pkg::cfg_t live_cfg = '0;
  graf_pkg::res_t pending_results[$];
  logic           typed_valid  = 1'b0;
  graf_pkg::res_t typed_result = '0;
  directed_row_t  directed_rows[$];
  graf_pkg::cfg_t settings[$];

  int unsigned fail_count     = 0;
  int unsigned requests_taken = 0;
  int unsigned ok_count       = 0;
  int unsigned write_count    = 0;
  int unsigned idle_cycles    = 0;
  logic [7:0]  seen_status    = '0;

  guarded_register_access_filter_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .descriptor_addr  (req_beat.descriptor_addr),
    .descriptor_magic (req_beat.descriptor_magic),
    .owner_ptr        (req_beat.owner_ptr),
    .req_type         (req_beat.req_type),
    .width_bytes      (req_beat.width_bytes),
    .is_shared        (req_beat.is_shared),
    .target_addr      (req_beat.target_addr),
    .bit_mask         (req_beat.bit_mask),
    .write_value      (req_beat.write_value),
    .current_data     (req_beat.current_data),
    .active_owner     (req_beat.active_owner),
    .done             (done),
    .status           (status),
    .do_write         (do_write),
    .write_data       (write_data),
    .read_result      (read_result)
  );

  always #1 clk = ~clk;

  // Works out the outcome of one request under the given register setting.
  function automatic graf_pkg::res_t filter_outcome(input graf_pkg::req_t r,
                                                    input graf_pkg::cfg_t c);
    logic [32:0]    last_byte;
    logic [31:0]    owner_ofs;
    logic [31:0]    lanes;
    logic [31:0]    cur;
    logic [31:0]    merged;
    graf_pkg::res_t o;
    o         = '0;
    o.status  = graf_pkg::ST_OK;
    merged    = '0;
    last_byte = {1'b0, r.descriptor_addr} + 33'(graf_pkg::DESCRIPTOR_BYTES - 1);
    owner_ofs = r.owner_ptr - c.owner_table_start;
    case (r.width_bytes)
      graf_pkg::WIDTH_BYTE: lanes = 32'h0000_00FF;
      graf_pkg::WIDTH_HALF: lanes = 32'h0000_FFFF;
      default:              lanes = 32'hFFFF_FFFF;
    endcase
    cur = r.current_data & lanes;
    if (last_byte[32] || r.descriptor_addr < c.flash_low || r.descriptor_addr > c.flash_high ||
        last_byte[31:0] < c.flash_low || last_byte[31:0] > c.flash_high) begin
      o.status = graf_pkg::ST_FLASH;
    end else if (r.descriptor_magic != c.expected_magic) begin
      o.status = graf_pkg::ST_MAGIC;
    end else if (r.owner_ptr < c.owner_table_start) begin
      o.status = graf_pkg::ST_OWNER_PTR;
    end else if (!r.is_shared && owner_ofs[9:2] != r.active_owner) begin
      o.status = graf_pkg::ST_OWNER;
    end else if ((r.target_addr & graf_pkg::PERIPH_MASK) != graf_pkg::PERIPH_BASE &&
                 (r.target_addr & graf_pkg::SYS_MASK) != graf_pkg::SYS_BASE) begin
      o.status = graf_pkg::ST_ADDRESS;
    end else if (r.width_bytes != graf_pkg::WIDTH_BYTE &&
                 r.width_bytes != graf_pkg::WIDTH_HALF &&
                 r.width_bytes != graf_pkg::WIDTH_WORD) begin
      o.status = graf_pkg::ST_WIDTH;
    end else begin
      case (graf_pkg::op_t'(r.req_type))
        graf_pkg::OP_READ:      o.read_result = cur;
        graf_pkg::OP_READ_AND:  o.read_result = cur & r.bit_mask;
        graf_pkg::OP_WRITE:     merged = r.write_value;
        graf_pkg::OP_WRITE_AND: merged = cur & (r.write_value | ~r.bit_mask);
        graf_pkg::OP_WRITE_OR:  merged = cur | (r.write_value & r.bit_mask);
        graf_pkg::OP_WRITE_XOR: merged = cur ^ (r.write_value & r.bit_mask);
        graf_pkg::OP_REPLACE:   merged = (cur & ~r.bit_mask) | (r.write_value & r.bit_mask);
        default:                o.status = graf_pkg::ST_OP;
      endcase
      // Every operation from plain write upward stores data.
      if (o.status == graf_pkg::ST_OK && r.req_type >= graf_pkg::OP_WRITE) begin
        o.do_write   = 1'b1;
        o.write_data = merged & lanes;
      end
    end
    return o;
  endfunction

  // A rejected request carries only its status.
  function automatic graf_pkg::res_t rejected(input graf_pkg::status_t s);
    graf_pkg::res_t o;
    o        = '0;
    o.status = s;
    return o;
  endfunction

  function automatic void add_row(input graf_pkg::req_t beat, input logic known,
                                  input graf_pkg::res_t result);
    directed_row_t row;
    row.beat   = beat;
    row.known  = known;
    row.result = result;
    directed_rows.push_back(row);
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds a request that mostly gets past every guard, with one guard broken
  // now and then; one beat in five is plain noise.
  function automatic graf_pkg::req_t make_request(input graf_pkg::cfg_t c);
    graf_pkg::req_t r;
    logic [31:0]    room;
    r.descriptor_addr  = $urandom;
    r.descriptor_magic = $urandom;
    r.owner_ptr        = $urandom;
    r.req_type         = 3'($urandom_range(0, 7));
    r.width_bytes      = 4'($urandom_range(0, 15));
    r.is_shared        = 1'($urandom_range(0, 1));
    r.target_addr      = $urandom;
    r.bit_mask         = $urandom;
    r.write_value      = $urandom;
    r.current_data     = $urandom;
    r.active_owner     = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) return r;

    // Place the descriptor inside the window when one fits.
    room = c.flash_high - c.flash_low;
    if (c.flash_high >= c.flash_low && room >= graf_pkg::DESCRIPTOR_BYTES - 1) begin
      case ($urandom_range(0, 7))
        0:       r.descriptor_addr = c.flash_low;
        1:       r.descriptor_addr = c.flash_high - (graf_pkg::DESCRIPTOR_BYTES - 1);
        default: r.descriptor_addr = c.flash_low +
                   $urandom_range(0, room - (graf_pkg::DESCRIPTOR_BYTES - 1));
      endcase
    end
    r.descriptor_magic = c.expected_magic;
    r.owner_ptr = c.owner_table_start + ((32'($urandom_range(0, 3)) << 10) |
                  {22'd0, r.active_owner, 2'b00} | 32'($urandom_range(0, 3)));
    r.is_shared = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      r.target_addr = graf_pkg::PERIPH_BASE | ($urandom & ~graf_pkg::PERIPH_MASK);
    end else begin
      r.target_addr = graf_pkg::SYS_BASE | ($urandom & ~graf_pkg::SYS_MASK);
    end
    case ($urandom_range(0, 2))
      0:       r.width_bytes = graf_pkg::WIDTH_BYTE;
      1:       r.width_bytes = graf_pkg::WIDTH_HALF;
      default: r.width_bytes = graf_pkg::WIDTH_WORD;
    endcase
    r.req_type = ($urandom_range(0, 15) == 0) ? graf_pkg::OP_INVALID :
                 3'($urandom_range(0, 6));

    // Break a single guard so that the later checks are reached too.
    case ($urandom_range(0, 11))
      0: begin
        r.descriptor_addr = ($urandom_range(0, 1) == 1) ? c.flash_low - 1 :
                            c.flash_high - (graf_pkg::DESCRIPTOR_BYTES - 2);
      end
      1: r.descriptor_magic ^= 32'h1 << $urandom_range(0, 31);
      2: r.owner_ptr = c.owner_table_start - $urandom_range(1, 8);
      3: r.active_owner += 8'($urandom_range(1, 255));
      4: begin
        case ($urandom_range(0, 3))
          0:       r.target_addr = 32'h3FFF_FFFF;
          1:       r.target_addr = 32'h4400_0000;
          2:       r.target_addr = 32'hE00F_EFFF;
          default: r.target_addr = 32'hE010_0000;
        endcase
      end
      5: r.width_bytes = 4'($urandom_range(0, 15));
      default: ;
    endcase
    return r;
  endfunction

  // Drives one request beat and holds it until it is taken.
  task automatic send_request(input graf_pkg::req_t beat, input logic known,
                              input graf_pkg::res_t result, input int unsigned gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_beat     = beat;
    typed_valid  = known;
    typed_result = result;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stops sending and lets every outstanding result come back.
  task automatic wait_idle();
    start       = 1'b0;
    typed_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input graf_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reads one register back and compares it with the value last written.
  task automatic check_register(input graf_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_setting(input graf_pkg::cfg_t c);
    write_register(graf_pkg::REG_FLASH_LOW, c.flash_low);
    write_register(graf_pkg::REG_FLASH_HIGH, c.flash_high);
    write_register(graf_pkg::REG_MAGIC, c.expected_magic);
    write_register(graf_pkg::REG_OWNER_TABLE, c.owner_table_start);
    check_register(graf_pkg::REG_FLASH_LOW, c.flash_low);
    check_register(graf_pkg::REG_FLASH_HIGH, c.flash_high);
    check_register(graf_pkg::REG_MAGIC, c.expected_magic);
    check_register(graf_pkg::REG_OWNER_TABLE, c.owner_table_start);
  endtask

  // Result checking, request tracking and register shadowing, all on the rising edge.
  always @(posedge clk) begin
    graf_pkg::res_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        $error("done is unknown");
        fail_count++;
      end else if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (do_write !== want.do_write) begin
            $error("do_write: expected %0d, got %0d", want.do_write, do_write);
            fail_count++;
          end
          if (write_data !== want.write_data) begin
            $error("write_data: expected %h, got %h", want.write_data, write_data);
            fail_count++;
          end
          if (read_result !== want.read_result) begin
            $error("read_result: expected %h, got %h", want.read_result, read_result);
            fail_count++;
          end
          seen_status[want.status] = 1'b1;
          if (want.status == graf_pkg::ST_OK) ok_count++;
          if (want.do_write) write_count++;
        end
      end
      if (start && !busy) begin
        pending_results.push_back(typed_valid ? typed_result :
                                  filter_outcome(req_beat, live_cfg));
        requests_taken++;
      end
      if (psel && penable && pwrite && pready) begin
        case (graf_pkg::reg_idx_t'(paddr[graf_pkg::CFG_ADDR_W-1:2]))
          graf_pkg::REG_FLASH_LOW:   live_cfg.flash_low         = pwdata;
          graf_pkg::REG_FLASH_HIGH:  live_cfg.flash_high        = pwdata;
          graf_pkg::REG_MAGIC:       live_cfg.expected_magic    = pwdata;
          graf_pkg::REG_OWNER_TABLE: live_cfg.owner_table_start = pwdata;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: ends the run when no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $error("no beat moved for %0d cycles, %0d results outstanding", IDLE_LIMIT,
             pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    graf_pkg::req_t good;
    graf_pkg::req_t row;
    graf_pkg::cfg_t setting;
    logic [31:0]    span;
    logic           steady;
    int unsigned    per_setting;

    // Directed table. The first rows run under the reset setting.
    good = '{descriptor_addr: DIR_FLASH_LOW + 32'h100, descriptor_magic: DIR_MAGIC,
             owner_ptr: DIR_TABLE + 32'h14, req_type: graf_pkg::OP_READ,
             width_bytes: graf_pkg::WIDTH_WORD,
             is_shared: 1'b0, target_addr: 32'h4000_1000, bit_mask: 32'h0F0F_F0F0,
             write_value: 32'hDEAD_BEEF, current_data: 32'h1234_5678, active_owner: 8'd5};
    add_row(good, 1'b1, rejected(graf_pkg::ST_FLASH));
    add_row('1, 1'b1, rejected(graf_pkg::ST_FLASH));

    // Window edges: the last descriptor byte may sit exactly on flash_high.
    row = good; row.descriptor_addr = DIR_FLASH_LOW - 1;
    add_row(row, 1'b1, rejected(graf_pkg::ST_FLASH));
    row = good; row.descriptor_addr = DIR_FLASH_HIGH - (graf_pkg::DESCRIPTOR_BYTES - 1);
    add_row(row, 1'b0, '0);
    row = good; row.descriptor_addr = DIR_FLASH_HIGH - (graf_pkg::DESCRIPTOR_BYTES - 2);
    add_row(row, 1'b1, rejected(graf_pkg::ST_FLASH));
    row = good; row.descriptor_addr = DIR_FLASH_LOW; row.descriptor_magic = ~DIR_MAGIC;
    add_row(row, 1'b1, rejected(graf_pkg::ST_MAGIC));

    // Owner pointer below the table, owner zero, wrong owner, shared, id wrap.
    row = good; row.owner_ptr = DIR_TABLE - 4;
    add_row(row, 1'b1, rejected(graf_pkg::ST_OWNER_PTR));
    row = good; row.owner_ptr = DIR_TABLE; row.active_owner = 8'd0;
    row.req_type = graf_pkg::OP_READ_AND; row.width_bytes = graf_pkg::WIDTH_HALF;
    add_row(row, 1'b0, '0);
    row = good; row.active_owner = 8'd6;
    add_row(row, 1'b1, rejected(graf_pkg::ST_OWNER));
    row = good; row.active_owner = 8'hFF; row.is_shared = 1'b1;
    row.req_type = graf_pkg::OP_WRITE; row.width_bytes = graf_pkg::WIDTH_BYTE;
    add_row(row, 1'b0, '0);
    row = good; row.owner_ptr = DIR_TABLE + 32'h400 + 32'h1C + 32'h3; row.active_owner = 8'd7;
    row.req_type = graf_pkg::OP_WRITE_AND;
    add_row(row, 1'b0, '0);

    // Target window boundaries.
    row = good; row.target_addr = 32'h3FFF_FFFF;
    add_row(row, 1'b1, rejected(graf_pkg::ST_ADDRESS));
    row = good; row.target_addr = 32'h43FF_FFFF; row.req_type = graf_pkg::OP_WRITE_OR;
    add_row(row, 1'b0, '0);
    row = good; row.target_addr = 32'h4400_0000;
    add_row(row, 1'b1, rejected(graf_pkg::ST_ADDRESS));
    row = good; row.target_addr = 32'hE00F_F000; row.req_type = graf_pkg::OP_WRITE_XOR;
    add_row(row, 1'b0, '0);
    row = good; row.target_addr = 32'hE00F_FFFF; row.req_type = graf_pkg::OP_REPLACE;
    row.width_bytes = graf_pkg::WIDTH_HALF;
    add_row(row, 1'b0, '0);
    row = good; row.target_addr = 32'hE010_0000;
    add_row(row, 1'b1, rejected(graf_pkg::ST_ADDRESS));
    row = good; row.target_addr = 32'hE00F_EFFF;
    add_row(row, 1'b1, rejected(graf_pkg::ST_ADDRESS));

    // Widths outside 1, 2 and 4; a bad width outranks a bad operation.
    row = good; row.width_bytes = 4'd0;
    add_row(row, 1'b1, rejected(graf_pkg::ST_WIDTH));
    row = good; row.width_bytes = 4'd15; row.req_type = graf_pkg::OP_INVALID;
    add_row(row, 1'b1, rejected(graf_pkg::ST_WIDTH));
    row = good; row.width_bytes = 4'd3;
    add_row(row, 1'b1, rejected(graf_pkg::ST_WIDTH));
    row = good; row.req_type = graf_pkg::OP_INVALID;
    add_row(row, 1'b1, rejected(graf_pkg::ST_OP));

    // Data extremes.
    row = good; row.req_type = graf_pkg::OP_REPLACE; row.bit_mask = '1; row.write_value = '1;
    row.current_data = '0;
    add_row(row, 1'b0, '0);
    row = good; row.width_bytes = graf_pkg::WIDTH_BYTE; row.current_data = '1;
    add_row(row, 1'b0, '0);

    // Register settings for the random part: extremes first, then random windows.
    settings.push_back('{flash_low: 32'h0, flash_high: 32'hFFFF_FFFF,
                         expected_magic: 32'h0, owner_table_start: 32'h0});
    settings.push_back('{flash_low: 32'hFFFF_FFEC, flash_high: 32'hFFFF_FFFF,
                         expected_magic: 32'hFFFF_FFFF, owner_table_start: 32'hFFFF_FC00});
    settings.push_back('{flash_low: 32'h0, flash_high: 32'h13,
                         expected_magic: 32'hA5A5_5A5A, owner_table_start: 32'hFFFF_FFFF});
    for (int k = 0; k < 4; k++) begin
      setting.flash_low = $urandom;
      case ($urandom_range(0, 2))
        0:       span = $urandom_range(graf_pkg::DESCRIPTOR_BYTES - 1, 64);
        1:       span = $urandom_range(graf_pkg::DESCRIPTOR_BYTES - 1, 32'h000F_FFFF);
        default: span = $urandom;
      endcase
      setting.flash_high = (setting.flash_low > ~span) ? 32'hFFFF_FFFF :
                           setting.flash_low + span;
      setting.expected_magic    = $urandom;
      setting.owner_table_start = $urandom;
      settings.push_back(setting);
    end
    per_setting = RANDOM_ITEMS / settings.size();

    // Reset, then the directed rows.
    repeat (8) @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i]) begin
      if (i == RESET_ROWS) begin
        wait_idle();
        program_setting('{flash_low: DIR_FLASH_LOW, flash_high: DIR_FLASH_HIGH,
                          expected_magic: DIR_MAGIC, owner_table_start: DIR_TABLE});
      end
      send_request(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].result,
                   pick_gap());
    end

    // Random part, one block of requests per register setting.
    steady = 1'b0;
    foreach (settings[p]) begin
      wait_idle();
      program_setting(settings[p]);
      for (int n = 0; n < per_setting; n++) begin
        if (n % 64 == 0) steady = ($urandom_range(0, 2) == 0);
        send_request(make_request(settings[p]), 1'b0, '0, steady ? 0 : pick_gap());
      end
    end
    wait_idle();

    $display("Covered %0d requests over %0d register settings plus the reset setting.",
             requests_taken, settings.size() + 1);
    $display("Results: %0d passed every guard (%0d with a store), %0d of 8 status codes seen.",
             ok_count, write_count, $countones(seen_status));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/graf_pkg.sv
sv/graf_cfg.sv
sv/graf_check.sv
sv/graf_op.sv
sv/guarded_register_access_filter_unit.sv
verif/tb_top.sv
